// ===== hdl/vfv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types and codes for the voxel face visibility block: request and
// result beats, command codes and the step codes of the query sequencer.
// ----------------------------------------------------------------------------
package vfv_pkg;

  localparam int COORD_BITS = 4;
  localparam int NEW_TYPE_BITS = 8;
  localparam int MASK_BITS = 6;
  localparam int STEP_BITS = 3;

  // command codes
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // sequencer steps: one memory read per step, the last step only drains
  localparam logic [STEP_BITS-1:0] DIR_CENTER = 3'd0;
  localparam logic [STEP_BITS-1:0] DIR_XP     = 3'd1;
  localparam logic [STEP_BITS-1:0] DIR_XN     = 3'd2;
  localparam logic [STEP_BITS-1:0] DIR_YP     = 3'd3;
  localparam logic [STEP_BITS-1:0] DIR_YN     = 3'd4;
  localparam logic [STEP_BITS-1:0] DIR_ZP     = 3'd5;
  localparam logic [STEP_BITS-1:0] DIR_ZN     = 3'd6;
  localparam logic [STEP_BITS-1:0] STEP_LAST  = 3'd7;

  typedef struct packed {
    logic                     command;
    logic [COORD_BITS-1:0]    cell_x;
    logic [COORD_BITS-1:0]    cell_y;
    logic [COORD_BITS-1:0]    cell_z;
    logic [NEW_TYPE_BITS-1:0] new_type;
  } vfv_req_t;

  typedef struct packed {
    logic                 solid;
    logic [MASK_BITS-1:0] face_mask;
  } vfv_res_t;

endpackage

// ===== hdl/vfv_cell_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_cell_ram
// Single-port cell type store, one write or one read per cycle, registered
// read data.
// ----------------------------------------------------------------------------
module vfv_cell_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/vfv_addr_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_addr_unit
// Shared address unit: offsets a base cell by one step direction, checks the
// result against the grid bounds and forms the linear cell address.
// ----------------------------------------------------------------------------
module vfv_addr_unit import vfv_pkg::*; #(
  parameter int GRID_SIZE = 16,
  parameter int AW        = 12
) (
  input  logic [COORD_BITS-1:0] x_i,
  input  logic [COORD_BITS-1:0] y_i,
  input  logic [COORD_BITS-1:0] z_i,
  input  logic [STEP_BITS-1:0]  dir_i,
  output logic                  in_grid_o,
  output logic [AW-1:0]         addr_o
);

  logic [COORD_BITS:0] nx, ny, nz;
  logic                under;
  logic [31:0]         idx;

  always_comb begin
    nx    = {1'b0, x_i};
    ny    = {1'b0, y_i};
    nz    = {1'b0, z_i};
    under = 1'b0;
    unique case (dir_i)
      DIR_XP: nx = {1'b0, x_i} + 1'b1;
      DIR_XN: begin
        under = (x_i == '0);
        nx    = {1'b0, x_i} - 1'b1;
      end
      DIR_YP: ny = {1'b0, y_i} + 1'b1;
      DIR_YN: begin
        under = (y_i == '0);
        ny    = {1'b0, y_i} - 1'b1;
      end
      DIR_ZP: nz = {1'b0, z_i} + 1'b1;
      DIR_ZN: begin
        under = (z_i == '0);
        nz    = {1'b0, z_i} - 1'b1;
      end
      default: ;
    endcase
    in_grid_o = !under && (int'(nx) < GRID_SIZE) && (int'(ny) < GRID_SIZE)
                && (int'(nz) < GRID_SIZE);
    idx    = (32'(nx) * 32'(GRID_SIZE) + 32'(ny)) * 32'(GRID_SIZE) + 32'(nz);
    addr_o = idx[AW-1:0];
  end

endmodule

// ===== hdl/voxel_face_visibility.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_visibility
// Cubic voxel grid of block types with hidden-face culling queries.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats enter on req_i, taken at a clock edge where start is high
//   and busy is low. A set beat writes the cell type in its accept cycle and
//   returns nothing; busy stays low, so sets can be issued every cycle.
//   A query beat raises busy: the cell and its six neighbors are read one
//   per cycle from a single-port cell memory, and a final drain step takes
//   the last read data. The result appears on res_o with res_valid_o high
//   for exactly one cycle, the first cycle with busy low again. A new
//   request may be accepted at the edge that takes the result, so queries
//   do not overlap: no request is taken while a query is in flight.
//   The receiver cannot stall: each result beat is taken in its strobe cycle.
//   Reset: after rst_ni is released the block clears the cell memory to air,
//   one cell per cycle, holding busy high until all GRID_SIZE^3 cells
//   (4096 at the default size) are cleared.
// ----------------------------------------------------------------------------
module voxel_face_visibility import vfv_pkg::*; #(
  parameter int GRID_SIZE = 16,
  parameter int TYPE_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  vfv_req_t req_i,
  output logic     res_valid_o,
  output vfv_res_t res_o
);

  localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_QUERY = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [AW-1:0]         clr_cnt_q;
  logic [STEP_BITS-1:0]  step_q;
  logic [COORD_BITS-1:0] x_q, y_q, z_q;
  logic                  rd_in_q;
  logic                  solid_q;
  logic [MASK_BITS-1:0]  mask_q;
  logic                  res_valid_q;
  vfv_res_t              res_q;

  logic                  accept;
  logic [COORD_BITS-1:0] au_x, au_y, au_z;
  logic [STEP_BITS-1:0]  au_dir;
  logic                  au_in_grid;
  logic [AW-1:0]         au_addr;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [TYPE_BITS-1:0]  ram_wdata;
  logic [TYPE_BITS-1:0]  ram_rdata;
  logic [TYPE_BITS+NEW_TYPE_BITS-1:0] type_ext;
  logic                  air;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // address unit sees the request in idle, the held cell while querying
  always_comb begin
    if (state_q == ST_IDLE) begin
      au_x   = req_i.cell_x;
      au_y   = req_i.cell_y;
      au_z   = req_i.cell_z;
      au_dir = DIR_CENTER;
    end else begin
      au_x   = x_q;
      au_y   = y_q;
      au_z   = z_q;
      au_dir = step_q;
    end
  end

  vfv_addr_unit #(
    .GRID_SIZE(GRID_SIZE),
    .AW       (AW)
  ) u_addr (
    .x_i      (au_x),
    .y_i      (au_y),
    .z_i      (au_z),
    .dir_i    (au_dir),
    .in_grid_o(au_in_grid),
    .addr_o   (au_addr)
  );

  // types keep their low TYPE_BITS bits
  assign type_ext = {{TYPE_BITS{1'b0}}, req_i.new_type};

  always_comb begin
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_we    = accept && (req_i.command == CMD_SET) && au_in_grid;
        ram_addr  = au_addr;
        ram_wdata = type_ext[TYPE_BITS-1:0];
      end
      default: begin
        ram_we    = 1'b0;
        ram_addr  = au_addr;
        ram_wdata = '0;
      end
    endcase
  end

  vfv_cell_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (TYPE_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // data of the read issued last step; outside the grid counts as air
  assign air = !rd_in_q || (ram_rdata == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (req_i.command == CMD_QUERY)) state_d = ST_QUERY;
      end
      ST_QUERY: begin
        if (step_q == STEP_LAST) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      step_q      <= DIR_CENTER;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_QUERY) && (step_q == STEP_LAST);
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == ST_QUERY) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= DIR_CENTER;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= req_i.cell_x;
      y_q <= req_i.cell_y;
      z_q <= req_i.cell_z;
    end
    rd_in_q <= au_in_grid;
    if (state_q == ST_QUERY) begin
      if (step_q == DIR_XP) begin
        solid_q <= !air;
      end else if (step_q != DIR_CENTER) begin
        // face bits shift in from the top, +x lands in bit 0
        mask_q <= {air, mask_q[MASK_BITS-1:1]};
      end
      if (step_q == STEP_LAST) begin
        res_q.solid     <= solid_q;
        res_q.face_mask <= solid_q ? {air, mask_q[MASK_BITS-1:1]} : '0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_air_no_faces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.solid || (res_o.face_mask == '0)))
    else $error("air cell reported visible faces");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held longer than one cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.command == CMD_QUERY)) |=> (busy && (step_q == DIR_CENTER)))
    else $error("query accepted without starting the read sequence");

  a_result_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == ST_QUERY && $past(step_q) == STEP_LAST))
    else $error("result strobe without a finished query");
`endif

endmodule
